/* rtl/hlvn_pkg.sv */
// ----------------------------------------------------------------------------
// hlvn_pkg
// Shared formats, hash constants and helpers for the hashed lattice value
// noise pipeline.
// ----------------------------------------------------------------------------
package hlvn_pkg;

    // Fraction bits of the coordinates and bits kept of each corner hash
    localparam int FRAC_BITS  = 16;
    localparam int VALUE_BITS = 16;

    // Pipeline depth: four hash/smoothing stages, three blend stages
    localparam int NUM_STAGES  = 7;
    localparam int FRONT_STAGES = 4;
    localparam int BLEND_STAGES = NUM_STAGES - FRONT_STAGES;

    // Corner hash multipliers
    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] HASH_MUL_Z = 32'd1274126177;

    // Output alignment to Q0.16
    localparam int OUT_SHR = (VALUE_BITS >= 16) ? VALUE_BITS - 16 : 0;
    localparam int OUT_SHL = (VALUE_BITS >= 16) ? 0 : 16 - VALUE_BITS;

    typedef logic [FRAC_BITS-1:0]  t_frac;
    typedef logic [VALUE_BITS-1:0] t_val;

    // Wrapping 32-bit multiply, low half only
    function automatic logic [31:0] f_mul32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] p;
        p = a * b;
        return p;
    endfunction

    // Blend a towards b by s, truncating: a + floor((b - a) * s / 2^FRAC_BITS)
    function automatic t_val f_lerp(input t_val a, input t_val b, input t_frac s);
        logic signed [VALUE_BITS:0]             d;
        logic signed [VALUE_BITS+FRAC_BITS+1:0] p;
        logic signed [VALUE_BITS+FRAC_BITS+1:0] q;
        logic signed [VALUE_BITS+1:0]           r;
        d = signed'({1'b0, b}) - signed'({1'b0, a});
        p = (VALUE_BITS+FRAC_BITS+2)'(d) * (VALUE_BITS+FRAC_BITS+2)'(signed'({1'b0, s}));
        q = p >>> FRAC_BITS;
        r = signed'({2'b00, a}) + q[VALUE_BITS+1:0];
        return r[VALUE_BITS-1:0];
    endfunction

endpackage

/* rtl/hlvn_front.sv */
// ----------------------------------------------------------------------------
// hlvn_front
// Lattice cell hashing and fraction smoothing, four register stages.
// Delivers the eight corner values and the three smoothed fractions.
// ----------------------------------------------------------------------------
module hlvn_front (
    input  logic                                   i_clk,
    input  logic [hlvn_pkg::FRONT_STAGES-1:0]      i_load,
    input  logic signed [31:0]                     i_pos_x,
    input  logic signed [31:0]                     i_pos_y,
    input  logic signed [31:0]                     i_pos_z,
    output hlvn_pkg::t_val                         o_corner [8],
    output hlvn_pkg::t_frac                        o_smooth [3]
);
    import hlvn_pkg::*;

    localparam logic [31:0] HASH_MUL [3] = '{HASH_MUL_X, HASH_MUL_Y, HASH_MUL_Z};
    localparam logic [FRAC_BITS+1:0] K_THREE = (FRAC_BITS+2)'(3) << FRAC_BITS;

    logic signed [31:0]       w_pos [3];
    logic [31:0]              n1_prod [3];
    t_frac                    n1_t [3];
    logic [2*FRAC_BITS-1:0]   n1_tt [3];
    logic [31:0]              r1_prod [3];
    t_frac                    r1_t [3];
    logic [2*FRAC_BITS-1:0]   r1_tt [3];
    logic [31:0]              n2_sum [8];
    t_frac                    n2_s [3];
    logic [31:0]              r2_sum [8];
    t_frac                    r2_s [3];
    logic [31:0]              n3_mix [8];
    logic [31:0]              r3_mix [8];
    t_frac                    r3_s [3];
    t_val                     n4_corner [8];
    t_val                     r4_corner [8];
    t_frac                    r4_s [3];

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;

    // Stage 1: floor to the cell, scale by the axis multiplier, square the fraction
    always_comb begin
        logic signed [31:0] lat_idx;
        for (int a = 0; a < 3; a++) begin
            lat_idx    = w_pos[a] >>> FRAC_BITS;
            n1_prod[a] = f_mul32(lat_idx, HASH_MUL[a]);
            n1_t[a]    = w_pos[a][FRAC_BITS-1:0];
            n1_tt[a]   = (2*FRAC_BITS)'(n1_t[a]) * (2*FRAC_BITS)'(n1_t[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r1_prod <= n1_prod;
            r1_t    <= n1_t;
            r1_tt   <= n1_tt;
        end
    end

    // Stage 2: sum the axis terms per corner (cell+1 adds the multiplier once),
    // finish the smoothstep t*t*(3-2t)
    always_comb begin
        logic [31:0]            px;
        logic [31:0]            py;
        logic [31:0]            pz;
        logic [FRAC_BITS-1:0]   t2;
        logic [FRAC_BITS+1:0]   k;
        logic [2*FRAC_BITS+1:0] p;
        for (int i = 0; i < 8; i++) begin
            px = ((i & 1) != 0) ? r1_prod[0] + HASH_MUL[0] : r1_prod[0];
            py = ((i & 2) != 0) ? r1_prod[1] + HASH_MUL[1] : r1_prod[1];
            pz = ((i & 4) != 0) ? r1_prod[2] + HASH_MUL[2] : r1_prod[2];
            n2_sum[i] = px + py + pz;
        end
        for (int a = 0; a < 3; a++) begin
            t2      = r1_tt[a][2*FRAC_BITS-1:FRAC_BITS];
            k       = K_THREE - {1'b0, r1_t[a], 1'b0};
            p       = (2*FRAC_BITS+2)'(t2) * (2*FRAC_BITS+2)'(k);
            n2_s[a] = p[2*FRAC_BITS-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r2_sum <= n2_sum;
            r2_s   <= n2_s;
        end
    end

    // Stage 3: first xor-shift and the mixing multiply
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n3_mix[i] = f_mul32(r2_sum[i] ^ (r2_sum[i] >> 13), HASH_MUL_Z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r3_mix <= n3_mix;
            r3_s   <= r2_s;
        end
    end

    // Stage 4: final xor-shift, keep the top bits as the corner value
    always_comb begin
        logic [31:0] h;
        for (int i = 0; i < 8; i++) begin
            h            = r3_mix[i] ^ (r3_mix[i] >> 16);
            n4_corner[i] = h[31:32-VALUE_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r4_corner <= n4_corner;
            r4_s      <= r3_s;
        end
    end

    assign o_corner = r4_corner;
    assign o_smooth = r4_s;

endmodule

/* rtl/hlvn_blend.sv */
// ----------------------------------------------------------------------------
// hlvn_blend
// Trilinear blend of the eight corner values, one axis per register stage,
// and alignment of the result to Q0.16.
// ----------------------------------------------------------------------------
module hlvn_blend (
    input  logic                                   i_clk,
    input  logic [hlvn_pkg::BLEND_STAGES-1:0]      i_load,
    input  hlvn_pkg::t_val                         i_corner [8],
    input  hlvn_pkg::t_frac                        i_smooth [3],
    output logic [15:0]                            o_noise_value
);
    import hlvn_pkg::*;

    t_val         n5_x [4];
    t_val         r5_x [4];
    t_frac        r5_sy;
    t_frac        r5_sz;
    t_val         n6_y [2];
    t_val         r6_y [2];
    t_frac        r6_sz;
    logic [15:0]  n7_out;
    logic [15:0]  r7_out;

    // Stage 5: blend along x, pairs differ only in the x corner
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n5_x[j] = f_lerp(i_corner[2*j], i_corner[2*j+1], i_smooth[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r5_x  <= n5_x;
            r5_sy <= i_smooth[1];
            r5_sz <= i_smooth[2];
        end
    end

    // Stage 6: blend along y, near and far z planes
    assign n6_y[0] = f_lerp(r5_x[0], r5_x[1], r5_sy);
    assign n6_y[1] = f_lerp(r5_x[2], r5_x[3], r5_sy);

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r6_y  <= n6_y;
            r6_sz <= r5_sz;
        end
    end

    // Stage 7: blend along z, align to Q0.16
    always_comb begin
        t_val                 v;
        logic [VALUE_BITS+15:0] w;
        v      = f_lerp(r6_y[0], r6_y[1], r6_sz);
        w      = (VALUE_BITS+16)'(v) << OUT_SHL;
        w      = w >> OUT_SHR;
        n7_out = w[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r7_out <= n7_out;
        end
    end

    assign o_noise_value = r7_out;

endmodule

/* rtl/hashed_lattice_value_noise_3d.sv */
// Throughput: one request per cycle while the output is not stalled; the seven-stage pipeline is the limit.
// Each stage holds only while its successor is full and stalled, so bubbles
// close up and input keeps flowing into empty stages while a finished result waits.
// Reset (synchronous, active low) clears every stage valid bit.
// ----------------------------------------------------------------------------
// hashed_lattice_value_noise_3d
// Trilinear value noise over a hashed 3D integer lattice, Q16.16 in, Q0.16 out.
// ----------------------------------------------------------------------------
module hashed_lattice_value_noise_3d (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_noise_value
);
    import hlvn_pkg::*;

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES:0]   w_rdy;
    t_val                  w_corner [8];
    t_frac                 w_smooth [3];

    // Stage load enables: a stage advances when empty or its successor advances
    always_comb begin
        w_rdy[NUM_STAGES] = !i_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_valid[k] || w_rdy[k+1];
        end
    end

    // Advance the valid bits with their stages
    always_comb begin
        n_valid = r_valid;
        if (w_rdy[0]) begin
            n_valid[0] = i_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_rdy[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    hlvn_front u_front (
        .i_clk    (i_clk),
        .i_load   (w_rdy[FRONT_STAGES-1:0]),
        .i_pos_x  (i_pos_x),
        .i_pos_y  (i_pos_y),
        .i_pos_z  (i_pos_z),
        .o_corner (w_corner),
        .o_smooth (w_smooth)
    );

    hlvn_blend u_blend (
        .i_clk         (i_clk),
        .i_load        (w_rdy[NUM_STAGES-1:FRONT_STAGES]),
        .i_corner      (w_corner),
        .i_smooth      (w_smooth),
        .o_noise_value (o_noise_value)
    );

    assign o_stall = !w_rdy[0];
    assign o_valid = r_valid[NUM_STAGES-1];

endmodule

/* rtl/hlvn_checker.sv */
// ----------------------------------------------------------------------------
// hlvn_checker
// Port-level checks on the noise pipeline: output handshake and the count
// of requests in flight.
// ----------------------------------------------------------------------------
module hlvn_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [15:0]        o_noise_value
);
    import hlvn_pkg::*;

    logic [3:0] r_inflight;
    logic [3:0] n_inflight;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    // Track requests accepted but not yet delivered
    always_comb begin
        n_inflight = r_inflight;
        if (w_in_acc && !w_out_acc) begin
            n_inflight = r_inflight + 4'd1;
        end else if (!w_in_acc && w_out_acc) begin
            n_inflight = r_inflight - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_noise_value))
        else $error("stalled result dropped or changed");

    // Never show a result without a request behind it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_inflight != 4'd0)
        else $error("result without an accepted request");

    // Never hold more requests than there are stages
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 4'(NUM_STAGES))
        else $error("more requests in flight than pipeline stages");

    // Never stall the input while the pipeline is empty
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight == 4'd0 |-> !o_stall)
        else $error("input stalled with an empty pipeline");

endmodule

bind hashed_lattice_value_noise_3d hlvn_checker u_hlvn_checker (.*);
